[rtl/kfd_pkg.sv]
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared types and constants of the KISS frame decoder.
// ----------------------------------------------------------------------------
package kfd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 11;
   localparam int ADDR_W = 3;

   // largest payload the block will ever accept, whatever the limit register says
   localparam int MAX_PAYLOAD = 1024;
   localparam logic [LEN_W-1:0] LIMIT_CEIL =
      (MAX_PAYLOAD > (2**LEN_W - 1)) ? {LEN_W{1'b1}} : LEN_W'(MAX_PAYLOAD);

   // highest plain command code, and the extra code accepted beside it
   localparam logic [BYTE_W-1:0] CMD_MAX   = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_EXTRA = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

   // register indexes
   localparam logic [ADDR_W-1:0] CSR_FRAME_END   = 3'd0;
   localparam logic [ADDR_W-1:0] CSR_ESCAPE      = 3'd1;
   localparam logic [ADDR_W-1:0] CSR_ESC_END     = 3'd2;
   localparam logic [ADDR_W-1:0] CSR_ESC_ESCAPE  = 3'd3;
   localparam logic [ADDR_W-1:0] CSR_LIMIT       = 3'd4;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_FRAME_END  = 8'hC0;
   localparam logic [BYTE_W-1:0] RST_ESCAPE     = 8'hDB;
   localparam logic [BYTE_W-1:0] RST_ESC_END    = 8'hDC;
   localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE = 8'hDD;
   localparam logic [LEN_W-1:0]  RST_LIMIT      = 11'd1024;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_CMD  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_BADCMD   = 3'd2,
      KIND_EMPTY    = 3'd3,
      KIND_BADESC   = 3'd4,
      KIND_OVERFLOW = 3'd5
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_end;
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] esc_end;
      logic [BYTE_W-1:0] esc_escape;
      logic [LEN_W-1:0]  limit;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic              esc_pending;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  count;
   } state_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] payload;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  length;
   } result_type;

endpackage

[rtl/kiss_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// kiss_frame_decoder_top
// KISS deframer: raw serial bytes in, un-escaped payload and frame events out.
// ----------------------------------------------------------------------------
// One raw byte is taken per clock cycle, back to back without a gap: the
// decoder state is updated in the cycle of the transfer and the result, when
// the byte produces one, appears in the result register on the next cycle.
// req_tready stays high while that register is empty or being taken, so the
// sustained rate is one byte per cycle as long as the result side keeps up.
// Frame delimiting, escape codes and the payload limit are set through the
// csr write port while no byte is in flight; the block does not enforce
// this, the user must keep to it. The limit is capped at the package maximum payload.
module kiss_frame_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] in_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [7:0] payload_byte, [15:8] command,
                                                    // [26:16] frame_length, rest zero
   output logic [2:0]                  rsp_tuser,   // [2:0] kind
   input  logic                        csr_we,
   input  logic [kfd_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [kfd_pkg::LEN_W-1:0]   csr_wdata
);

   kfd_pkg::cfg_type    cfg_ff;
   kfd_pkg::state_type  state_ff;
   kfd_pkg::state_type  state_in;
   kfd_pkg::result_type result_in;
   logic                rsp_valid_ff;
   kfd_pkg::kind_type   kind_ff;
   logic [7:0]          payload_ff;
   logic [7:0]          command_ff;
   logic [10:0]         length_ff;
   logic                req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   kfd_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .in_byte    (req_tdata),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_end  <= kfd_pkg::RST_FRAME_END;
         cfg_ff.escape     <= kfd_pkg::RST_ESCAPE;
         cfg_ff.esc_end    <= kfd_pkg::RST_ESC_END;
         cfg_ff.esc_escape <= kfd_pkg::RST_ESC_ESCAPE;
         cfg_ff.limit      <= kfd_pkg::RST_LIMIT;
      end else if (csr_we) begin
         case (csr_addr)
            kfd_pkg::CSR_FRAME_END:  cfg_ff.frame_end  <= csr_wdata[7:0];
            kfd_pkg::CSR_ESCAPE:     cfg_ff.escape     <= csr_wdata[7:0];
            kfd_pkg::CSR_ESC_END:    cfg_ff.esc_end    <= csr_wdata[7:0];
            kfd_pkg::CSR_ESC_ESCAPE: cfg_ff.esc_escape <= csr_wdata[7:0];
            kfd_pkg::CSR_LIMIT:      cfg_ff.limit      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= kfd_pkg::PH_WAIT;
         state_ff.esc_pending <= 1'b0;
         state_ff.command     <= '0;
         state_ff.count       <= '0;
         rsp_valid_ff         <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= result_in.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded on every transfer that produces a result
   always_ff @(posedge clock) begin
      if (req_accept && result_in.valid) begin
         kind_ff    <= result_in.kind;
         payload_ff <= result_in.payload;
         command_ff <= result_in.command;
         length_ff  <= result_in.length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, length_ff, command_ff, payload_ff};
   assign rsp_tuser  = kind_ff;

endmodule

[rtl/kfd_step.sv]
// ----------------------------------------------------------------------------
// kfd_step
// Per-byte deframing decision: next decoder state and the result, if any.
// ----------------------------------------------------------------------------
module kfd_step (
   input  kfd_pkg::cfg_type           cfg,
   input  kfd_pkg::state_type         state,
   input  logic [kfd_pkg::BYTE_W-1:0] in_byte,
   output kfd_pkg::state_type         state_next,
   output kfd_pkg::result_type        result
);

   logic [kfd_pkg::LEN_W-1:0]  limit;
   logic [kfd_pkg::BYTE_W-1:0] data_byte;
   logic                       bad_escape;
   logic                       esc_start;

   assign limit = (cfg.limit < kfd_pkg::LIMIT_CEIL) ? cfg.limit : kfd_pkg::LIMIT_CEIL;

   always_comb begin
      state_next     = state;
      result         = '0;
      result.kind    = kfd_pkg::KIND_DATA;
      result.command = state.command;
      data_byte      = in_byte;
      bad_escape     = 1'b0;
      esc_start      = 1'b0;

      case (state.phase)
         kfd_pkg::PH_CMD: begin
            if (in_byte <= kfd_pkg::CMD_MAX || in_byte == kfd_pkg::CMD_EXTRA) begin
               state_next.command     = in_byte;
               state_next.count       = '0;
               state_next.esc_pending = 1'b0;
               state_next.phase       = kfd_pkg::PH_BODY;
            end else begin
               state_next.phase       = kfd_pkg::PH_WAIT;
               state_next.esc_pending = 1'b0;
               state_next.count       = '0;
               result.valid           = 1'b1;
               result.kind            = kfd_pkg::KIND_BADCMD;
               result.command         = in_byte;
            end
         end

         kfd_pkg::PH_BODY: begin
            if (in_byte == cfg.frame_end) begin
               result.valid  = 1'b1;
               result.length = state.count;
               state_next.esc_pending = 1'b0;
               state_next.count       = '0;
               if (state.esc_pending) begin
                  // the frame-end still opens the next frame
                  state_next.phase = kfd_pkg::PH_CMD;
                  result.kind      = kfd_pkg::KIND_BADESC;
               end else if (state.count == '0) begin
                  state_next.phase = kfd_pkg::PH_WAIT;
                  result.kind      = kfd_pkg::KIND_EMPTY;
               end else begin
                  state_next.phase = kfd_pkg::PH_CMD;
                  result.kind      = kfd_pkg::KIND_DONE;
               end
            end else begin
               if (state.esc_pending) begin
                  state_next.esc_pending = 1'b0;
                  if (in_byte == cfg.esc_end) begin
                     data_byte = cfg.frame_end;
                  end else if (in_byte == cfg.esc_escape) begin
                     data_byte = cfg.escape;
                  end else begin
                     bad_escape = 1'b1;
                  end
               end else if (in_byte == cfg.escape) begin
                  esc_start = 1'b1;
               end

               if (esc_start) begin
                  state_next.esc_pending = 1'b1;
               end else if (bad_escape || state.count >= limit) begin
                  state_next.phase       = kfd_pkg::PH_WAIT;
                  state_next.esc_pending = 1'b0;
                  state_next.count       = '0;
                  result.valid           = 1'b1;
                  result.kind            = bad_escape ? kfd_pkg::KIND_BADESC
                                                      : kfd_pkg::KIND_OVERFLOW;
                  result.length          = state.count;
               end else begin
                  state_next.count = state.count + 1'b1;
                  result.valid     = 1'b1;
                  result.kind      = kfd_pkg::KIND_DATA;
                  result.payload   = data_byte;
                  result.length    = state.count + 1'b1;
               end
            end
         end

         default: begin
            // waiting for a frame-end
            if (in_byte == cfg.frame_end) begin
               state_next.phase       = kfd_pkg::PH_CMD;
               state_next.esc_pending = 1'b0;
               state_next.count       = '0;
            end else begin
               state_next.phase       = kfd_pkg::PH_WAIT;
            end
         end
      endcase

      if (result.kind != kfd_pkg::KIND_DATA) begin
         result.payload = kfd_pkg::BYTE_ZERO;
      end
   end

endmodule

[rtl/kfd_checker.sv]
// ----------------------------------------------------------------------------
// kfd_checker
// Port-level checks on the KISS frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // input side never blocked while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= kfd_pkg::KIND_OVERFLOW)
      else $error("result kind out of range");

   // payload byte only on data results, data results always count at least one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != kfd_pkg::KIND_DATA |-> rsp_tdata[7:0] == 8'h00)
      else $error("payload byte set on a non-data result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == kfd_pkg::KIND_DATA || rsp_tuser == kfd_pkg::KIND_DONE)
      |-> rsp_tdata[26:16] != 11'd0 && rsp_tdata[31:27] == 5'd0)
      else $error("data or frame-complete result with zero length");

endmodule

bind kiss_frame_decoder_top kfd_checker u_kfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[bench/tb_kiss_frame_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kiss_frame_decoder_top
// Self-checking bench for the KISS frame decoder. A scripted opening walks
// the delimiter, command, escape and frame-end cases with default framing
// bytes. Randomised frames follow under several framing and limit settings,
// including remapped delimiters, a zero limit and a limit above the ceiling.
// Every result transfer is checked against an in-bench deframer, or against
// scripted events in the opening, with random gaps on the byte side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_kiss_frame_decoder_top;

   typedef struct packed {
      kfd_pkg::kind_type          kind;
      logic [kfd_pkg::BYTE_W-1:0] payload;
      logic [kfd_pkg::BYTE_W-1:0] command;
      logic [kfd_pkg::LEN_W-1:0]  length;
   } frame_event_type;

   typedef enum logic [1:0] {
      PREDICTED,
      NO_EVENT,
      FIXED_EVENT
   } check_mode_type;

   typedef struct {
      logic [kfd_pkg::BYTE_W-1:0] raw;
      check_mode_type             mode;
      frame_event_type            ev;
   } script_row_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = 8'h00;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [31:0]                  rsp_tdata;
   logic [2:0]                   rsp_tuser;
   logic                         csr_we     = 1'b0;
   logic [kfd_pkg::ADDR_W-1:0]   csr_addr   = kfd_pkg::CSR_FRAME_END;
   logic [kfd_pkg::LEN_W-1:0]    csr_wdata  = '0;

   // mirror of the framing registers
   logic [kfd_pkg::BYTE_W-1:0]   cfg_fe         = kfd_pkg::RST_FRAME_END;
   logic [kfd_pkg::BYTE_W-1:0]   cfg_esc        = kfd_pkg::RST_ESCAPE;
   logic [kfd_pkg::BYTE_W-1:0]   cfg_esc_end    = kfd_pkg::RST_ESC_END;
   logic [kfd_pkg::BYTE_W-1:0]   cfg_esc_escape = kfd_pkg::RST_ESC_ESCAPE;
   logic [kfd_pkg::LEN_W-1:0]    cfg_limit      = kfd_pkg::RST_LIMIT;

   // deframer state
   kfd_pkg::phase_type           dec_phase = kfd_pkg::PH_WAIT;
   logic                         dec_esc   = 1'b0;
   logic [kfd_pkg::BYTE_W-1:0]   dec_cmd   = '0;
   logic [kfd_pkg::LEN_W-1:0]    dec_count = '0;

   frame_event_type     expected_events[$];
   script_row_type      table_checks[$];
   script_row_type      opening_rows[26];
   int unsigned         mismatches = 0;
   int unsigned         items_sent = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct = 0;
   bit                  frame_open = 1'b0;

   kiss_frame_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("kiss_frame_decoder_top verification failed");
      $finish;
   end

   function automatic void back_to_wait();
      dec_phase = kfd_pkg::PH_WAIT;
      dec_esc   = 1'b0;
      dec_count = '0;
   endfunction

   // advances the deframer by one raw byte; returns 1 when it yields an event
   function automatic bit deframe_byte(input logic [kfd_pkg::BYTE_W-1:0] raw,
                                       output frame_event_type ev);
      logic [kfd_pkg::LEN_W-1:0]  ceiling;
      logic [kfd_pkg::BYTE_W-1:0] data;
      ceiling = (cfg_limit > kfd_pkg::LIMIT_CEIL) ? kfd_pkg::LIMIT_CEIL : cfg_limit;
      data    = raw;
      ev      = '0;
      if (dec_phase == kfd_pkg::PH_CMD) begin
         if (raw <= kfd_pkg::CMD_MAX || raw == kfd_pkg::CMD_EXTRA) begin
            dec_cmd   = raw;
            dec_count = '0;
            dec_esc   = 1'b0;
            dec_phase = kfd_pkg::PH_BODY;
            return 1'b0;
         end
         back_to_wait();
         ev = '{kfd_pkg::KIND_BADCMD, kfd_pkg::BYTE_ZERO, raw, kfd_pkg::LEN_W'(0)};
         return 1'b1;
      end
      if (dec_phase != kfd_pkg::PH_BODY) begin
         if (raw == cfg_fe) begin
            dec_phase = kfd_pkg::PH_CMD;
            dec_esc   = 1'b0;
            dec_count = '0;
         end
         return 1'b0;
      end
      if (raw == cfg_fe) begin
         if (dec_esc) begin
            // the delimiter still opens the next frame
            ev = '{kfd_pkg::KIND_BADESC, kfd_pkg::BYTE_ZERO, dec_cmd, dec_count};
            dec_phase = kfd_pkg::PH_CMD;
            dec_esc   = 1'b0;
            dec_count = '0;
         end else if (dec_count == 0) begin
            ev = '{kfd_pkg::KIND_EMPTY, kfd_pkg::BYTE_ZERO, dec_cmd, kfd_pkg::LEN_W'(0)};
            back_to_wait();
         end else begin
            ev = '{kfd_pkg::KIND_DONE, kfd_pkg::BYTE_ZERO, dec_cmd, dec_count};
            dec_phase = kfd_pkg::PH_CMD;
            dec_count = '0;
         end
         return 1'b1;
      end
      if (dec_esc) begin
         dec_esc = 1'b0;
         // end code wins when both codes are equal
         if (raw == cfg_esc_end) begin
            data = cfg_fe;
         end else if (raw == cfg_esc_escape) begin
            data = cfg_esc;
         end else begin
            ev = '{kfd_pkg::KIND_BADESC, kfd_pkg::BYTE_ZERO, dec_cmd, dec_count};
            back_to_wait();
            return 1'b1;
         end
      end else if (raw == cfg_esc) begin
         dec_esc = 1'b1;
         return 1'b0;
      end
      if (dec_count >= ceiling) begin
         ev = '{kfd_pkg::KIND_OVERFLOW, kfd_pkg::BYTE_ZERO, dec_cmd, dec_count};
         back_to_wait();
         return 1'b1;
      end
      dec_count = dec_count + 1'b1;
      ev = '{kfd_pkg::KIND_DATA, data, dec_cmd, dec_count};
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t ns", field, got, want, $time);
      mismatches++;
   endtask

   // result side: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // checks result transfers, then predicts for byte transfers
   always @(posedge clock) begin
      frame_event_type ev;
      frame_event_type want;
      script_row_type  row;
      bit              got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               note_mismatch("unexpected result", rsp_tdata, 32'h0);
            end else begin
               want = expected_events.pop_front();
               if (rsp_tuser != want.kind)
                  note_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
               if (rsp_tdata[7:0] != want.payload)
                  note_mismatch("payload_byte", 32'(rsp_tdata[7:0]), 32'(want.payload));
               if (rsp_tdata[15:8] != want.command)
                  note_mismatch("command", 32'(rsp_tdata[15:8]), 32'(want.command));
               if (rsp_tdata[26:16] != want.length)
                  note_mismatch("frame_length", 32'(rsp_tdata[26:16]), 32'(want.length));
               if (rsp_tdata[31:27] != '0)
                  note_mismatch("tdata padding", 32'(rsp_tdata[31:27]), 32'h0);
            end
         end
         if (req_tvalid && req_tready) begin
            got = deframe_byte(req_tdata, ev);
            if (table_checks.size() != 0) begin
               row = table_checks.pop_front();
               case (row.mode)
                  PREDICTED: begin
                     if (got) expected_events.push_back(ev);
                  end
                  FIXED_EVENT: begin
                     expected_events.push_back(row.ev);
                  end
                  default: begin
                  end
               endcase
            end else if (got) begin
               expected_events.push_back(ev);
            end
         end
      end
   end

   // one byte transfer, with random idle cycles ahead of it
   task automatic push_raw(input logic [kfd_pkg::BYTE_W-1:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // drains every predicted result and the result register
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0 || rsp_tvalid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [kfd_pkg::BYTE_W-1:0] fe,
                                 input logic [kfd_pkg::BYTE_W-1:0] esc,
                                 input logic [kfd_pkg::BYTE_W-1:0] esc_end,
                                 input logic [kfd_pkg::BYTE_W-1:0] esc_escape,
                                 input logic [kfd_pkg::LEN_W-1:0] limit);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= kfd_pkg::CSR_FRAME_END;
      csr_wdata <= kfd_pkg::LEN_W'(fe);
      @(posedge clock);
      csr_addr  <= kfd_pkg::CSR_ESCAPE;
      csr_wdata <= kfd_pkg::LEN_W'(esc);
      @(posedge clock);
      csr_addr  <= kfd_pkg::CSR_ESC_END;
      csr_wdata <= kfd_pkg::LEN_W'(esc_end);
      @(posedge clock);
      csr_addr  <= kfd_pkg::CSR_ESC_ESCAPE;
      csr_wdata <= kfd_pkg::LEN_W'(esc_escape);
      @(posedge clock);
      csr_addr  <= kfd_pkg::CSR_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_fe         = fe;
      cfg_esc        = esc;
      cfg_esc_end    = esc_end;
      cfg_esc_escape = esc_escape;
      cfg_limit      = limit;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned hold_pct);
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
   endtask

   // one frame: optional opener, command, escaped body, closing delimiter
   task automatic send_frame(input int unsigned len_lo, input int unsigned len_hi,
                             input bit clean);
      int unsigned                len;
      int unsigned                roll;
      logic [kfd_pkg::BYTE_W-1:0] data;
      if (!frame_open) push_raw(cfg_fe);
      roll = $urandom_range(7);
      if (!clean && $urandom_range(99) < 6)
         push_raw(8'($urandom_range(8'h07, 8'hFE)));
      else
         push_raw((roll == 7) ? kfd_pkg::CMD_EXTRA : 8'(roll));
      len = $urandom_range(len_hi, len_lo);
      for (int unsigned i = 0; i < len; i++) begin
         roll = $urandom_range(99);
         data = (roll < 12) ? cfg_fe : (roll < 24) ? cfg_esc : 8'($urandom);
         if (!clean && roll >= 97) begin
            // escape followed by an arbitrary byte
            push_raw(cfg_esc);
            push_raw(8'($urandom));
         end else if (data == cfg_fe) begin
            push_raw(cfg_esc);
            push_raw(cfg_esc_end);
         end else if (data == cfg_esc) begin
            push_raw(cfg_esc);
            push_raw(cfg_esc_escape);
         end else begin
            push_raw(data);
         end
      end
      if (!clean && $urandom_range(99) < 4) push_raw(cfg_esc);
      push_raw(cfg_fe);
      frame_open = (len != 0);
   endtask

   task automatic run_random(input int unsigned count, input int unsigned body_max);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(6, 1)) push_raw(8'($urandom));
            frame_open = 1'b0;
         end else begin
            send_frame(0, body_max, 1'b0);
         end
      end
   endtask

   task automatic pick_idling();
      case ($urandom_range(3))
         0: set_idling(0, 0);
         1: set_idling(71, 0);
         2: set_idling(0, 71);
         default: set_idling(16, 16);
      endcase
   endtask

   initial begin
      logic [kfd_pkg::LEN_W-1:0] limit;
      opening_rows = '{
         '{8'hDB, NO_EVENT,    '0},
         '{8'hC0, NO_EVENT,    '0},
         '{8'h07, FIXED_EVENT, '{kfd_pkg::KIND_BADCMD,  8'h00, 8'h07, 11'd0}},
         '{8'hC0, NO_EVENT,    '0},
         '{8'hC0, FIXED_EVENT, '{kfd_pkg::KIND_BADCMD,  8'h00, 8'hC0, 11'd0}},
         '{8'hC0, NO_EVENT,    '0},
         '{8'h00, NO_EVENT,    '0},
         '{8'hC0, FIXED_EVENT, '{kfd_pkg::KIND_EMPTY,   8'h00, 8'h00, 11'd0}},
         '{8'hC0, NO_EVENT,    '0},
         '{8'hFF, NO_EVENT,    '0},
         '{8'h00, FIXED_EVENT, '{kfd_pkg::KIND_DATA,    8'h00, 8'hFF, 11'd1}},
         '{8'hFF, FIXED_EVENT, '{kfd_pkg::KIND_DATA,    8'hFF, 8'hFF, 11'd2}},
         '{8'hDB, PREDICTED,   '0},
         '{8'hDC, PREDICTED,   '0},
         '{8'hDB, PREDICTED,   '0},
         '{8'hDD, PREDICTED,   '0},
         '{8'hDB, PREDICTED,   '0},
         '{8'hC0, FIXED_EVENT, '{kfd_pkg::KIND_BADESC,  8'h00, 8'hFF, 11'd4}},
         '{8'h06, NO_EVENT,    '0},
         '{8'h41, PREDICTED,   '0},
         '{8'hDB, NO_EVENT,    '0},
         '{8'hDB, FIXED_EVENT, '{kfd_pkg::KIND_BADESC,  8'h00, 8'h06, 11'd1}},
         '{8'hC0, NO_EVENT,    '0},
         '{8'h03, NO_EVENT,    '0},
         '{8'h55, PREDICTED,   '0},
         '{8'hC0, FIXED_EVENT, '{kfd_pkg::KIND_DONE,    8'h00, 8'h03, 11'd1}}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      foreach (opening_rows[i]) begin
         table_checks.push_back(opening_rows[i]);
         push_raw(opening_rows[i].raw);
      end
      frame_open = 1'b1;
      run_random(110, 12);

      apply_settings(kfd_pkg::RST_FRAME_END, kfd_pkg::RST_ESCAPE, kfd_pkg::RST_ESC_END,
                     kfd_pkg::RST_ESC_ESCAPE, 11'd1);
      set_idling(71, 0);
      run_random(110, 4);

      apply_settings(8'h00, 8'hFF, 8'h01, 8'hFE, 11'd5);
      set_idling(0, 71);
      run_random(110, 8);

      // limit above the ceiling
      apply_settings(8'hFF, 8'h00, 8'h80, 8'h7F, 11'd2047);
      set_idling(16, 16);
      run_random(110, 12);

      // zero limit: no payload byte is ever accepted as data
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 11'd0);
      set_idling(16, 16);
      run_random(60, 6);

      repeat (3) begin
         limit = ($urandom_range(3) == 0) ? kfd_pkg::LEN_W'($urandom_range(2047))
                                          : kfd_pkg::LEN_W'($urandom_range(16, 1));
         apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), limit);
         pick_idling();
         run_random(80, 20);
      end

      apply_settings(kfd_pkg::RST_FRAME_END, kfd_pkg::RST_ESCAPE, kfd_pkg::RST_ESC_END,
                     kfd_pkg::RST_ESC_ESCAPE, kfd_pkg::RST_LIMIT);
      set_idling(0, 0);
      frame_open = 1'b0;
      run_random(100, 12);

      settle();
      if (mismatches == 0) begin
         $display("kiss_frame_decoder_top verification clean");
      end else begin
         $display("kiss_frame_decoder_top verification failed");
      end
      $finish;
   end

endmodule
